### design/i2da_pkg.sv
// shared types, constants and the power-of-ten table for the decimal text converter
package i2da_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 7;
  localparam int unsigned PlaceW = 4;
  localparam int unsigned WeightW = 34;

  localparam logic [CharW-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CharW-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [PlaceW-1:0] TOP_PLACE = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } i2da_state_t;

  typedef struct packed {
    logic load;
    logic emit_sign;
    logic step;
  } i2da_cmd_t;

  typedef struct packed {
    logic in_neg;
    logic out_free;
    logic skip;
    logic k_zero;
  } i2da_status_t;

  function automatic logic [ValueW-1:0] pow10(input logic [PlaceW-1:0] k);
    logic [ValueW-1:0] p;
    case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

### design/int32_to_decimal_ascii_core.sv
// top level of the signed 32-bit to decimal ascii text converter
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_value (32, signed)
//   out_     output     out_valid/out_stall out_character (7), out_last (1)
//
// a number is taken in one transfer, then the minus sign is sent when it is negative,
// then ten place steps of the digit sequencer follow, one decimal place per cycle
// unless the output stalls, from the billions down, leading zeros dropped.
// a new number is taken only once the previous one's last character is registered.
// a stalled output holds the digit sequencer on its next character.
// reset is synchronous, active low, and clears the state machine and output valid.
module int32_to_decimal_ascii_core
  import i2da_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_character,
  output logic               out_last
);

  i2da_cmd_t    cmd;
  i2da_status_t status;

  i2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  i2da_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // a transfer in keeps the input closed while the number is converted
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a transfer");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS ||
                   (out_character >= CHAR_ZERO && out_character <= 7'd57)))
    else $error("output character is neither minus nor a digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_no_sign_and_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_sign && cmd.step))
    else $error("sign and digit issued in the same cycle");

endmodule

### design/i2da_ctrl.sv
// controller state machine: accept, sign and digit sequencing
module i2da_ctrl
  import i2da_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  i2da_status_t status,
  output i2da_cmd_t    cmd
);

  i2da_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.in_neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // leading zeros are dropped without waiting for the output slot
        if (status.skip || status.out_free) begin
          cmd.step = 1'b1;
          if (status.k_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/i2da_dp.sv
// datapath: magnitude, one decimal place per step, output register
module i2da_dp
  import i2da_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [31:0]  in_value,
  input  i2da_cmd_t           cmd,
  output i2da_status_t        status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CharW-1:0]    out_character,
  output logic                out_last
);

  logic [ValueW-1:0] raw;
  logic [ValueW-1:0] mag;
  logic [ValueW-1:0] rem_r, rem_nxt;
  logic [PlaceW-1:0] k_r, k_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CharW-1:0]  out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [ValueW-1:0] place_w;
  logic [3:0]        digit;
  logic [WeightW-1:0] wsel;
  logic              skip;
  logic              emit;

  assign raw = $unsigned(in_value);
  assign mag = raw[ValueW-1] ? (~raw + 32'd1) : raw;

  assign place_w = pow10(k_r);

  // digit of the current place: largest multiple of its weight that fits
  always_comb begin
    logic [WeightW-1:0] w;
    digit = '0;
    wsel  = '0;
    for (int c = 1; c < 10; c++) begin
      w = WeightW'(place_w) * WeightW'(c);
      if ({2'b00, rem_r} >= w) begin
        digit = 4'(c);
        wsel  = w;
      end
    end
  end

  assign skip = !started_r && (digit == 4'd0) && (k_r != 4'd0);
  assign emit = cmd.emit_sign || (cmd.step && !skip);

  assign status.in_neg   = raw[ValueW-1];
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.skip     = skip;
  assign status.k_zero   = (k_r == 4'd0);

  always_comb begin
    rem_nxt     = rem_r;
    k_nxt       = k_r;
    started_nxt = started_r;
    if (cmd.load) begin
      rem_nxt     = mag;
      k_nxt       = TOP_PLACE;
      started_nxt = 1'b0;
    end else if (cmd.step) begin
      rem_nxt     = rem_r - wsel[ValueW-1:0];
      k_nxt       = k_r - 4'd1;
      started_nxt = started_r || (digit != 4'd0);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + {3'b000, digit});
      out_last_nxt  = cmd.step && (k_r == 4'd0);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    k_r        <= k_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

### sim/int32_to_decimal_ascii_checker.sv
// watches both channels of the decimal text converter, predicts each character and compares
module int32_to_decimal_ascii_checker
  import i2da_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CharW-1:0]   out_character,
  input  logic               out_last,
  output int                 error_count,
  output int                 chars_pending,
  output int                 numbers_seen,
  output int                 chars_seen
);

  localparam int ReportMax = 10;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want;

  initial begin
    error_count   = 0;
    chars_pending = 0;
    numbers_seen  = 0;
    chars_seen    = 0;
  end

  // decimal text of one number, most significant digit first
  function automatic void queue_decimal_text(input logic [ValueW-1:0] raw);
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [3:0]        digit_buf[10];
    int                n_digits;
    neg = raw[ValueW-1];
    // magnitude as unsigned, so the most negative value needs no special path
    mag = neg ? (~raw + 1'b1) : raw;
    n_digits = 0;
    do begin
      digit_buf[n_digits] = 4'(mag % 10);
      mag = mag / 10;
      n_digits++;
    end while (mag != 0);
    if (neg) expected_text.push_back(text_char_t'{CHAR_MINUS, 1'b0});
    for (int k = n_digits - 1; k >= 0; k--) begin
      expected_text.push_back(text_char_t'{CHAR_ZERO + 7'(digit_buf[k]), k == 0});
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // outputs first: nothing accepted at this edge can already be due
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          error_count++;
          if (error_count <= ReportMax)
            $display("unexpected character transfer: got %0d last %0b",
                     out_character, out_last);
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== out_character || want.last !== out_last) begin
            error_count++;
            if (error_count <= ReportMax)
              $display("mismatch on character %0d: expected %0d last %0b, got %0d last %0b",
                       chars_seen, want.ch, want.last, out_character, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_decimal_text(in_value);
        numbers_seen++;
      end
      chars_pending = expected_text.size();
    end
  end

endmodule

### sim/tb_int32_to_decimal_ascii_core.sv
// stimulus, idling mixes and verdict for the decimal text converter
module tb_int32_to_decimal_ascii_core
  import i2da_pkg::*;
();

  localparam int WatchdogLimit  = 3000;
  localparam int HoldOffCycles  = 400;
  localparam int RandomPerPhase = 28;
  localparam int NumPhases      = 5;
  localparam int DrainCycles    = 40;
  localparam int NumDirected    = 22;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CharW-1:0]   out_character;
  logic               out_last;

  int error_count;
  int chars_pending;
  int numbers_seen;
  int chars_seen;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int negatives     = 0;
  int quiet_cycles  = 0;

  logic signed [31:0] directed_values[NumDirected] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sd12345, -32'sd67890, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
    32'sd1000000001, 32'sd1999999999, 32'sd2147483647, -32'sd2147483647,
    32'sh80000000, 32'sh55555555, 32'shAAAAAAAA, 32'sd2000000000
  };

  int phase_idle[NumPhases]  = '{0, 50, 0, 33, 0};
  int phase_stall[NumPhases] = '{0, 0, 50, 33, 0};

  always #5 clk = ~clk;

  int32_to_decimal_ascii_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  int32_to_decimal_ascii_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .error_count   (error_count),
    .chars_pending (chars_pending),
    .numbers_seen  (numbers_seen),
    .chars_seen    (chars_seen)
  );

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_left   = HoldOffCycles;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_value(input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_value = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    if (v < 0) negatives++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // mix of full-range values, short numbers, chosen digit counts and powers of ten
  function automatic logic signed [31:0] random_int32();
    logic signed [31:0] v;
    longint             lo;
    longint             hi;
    int                 n_digits;
    lo = 1;
    n_digits = $urandom_range(10, 1);
    repeat (n_digits - 1) lo = lo * 10;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: begin
        hi = lo * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        v = $urandom_range(int'(hi), int'(lo));
      end
      default: begin
        v = 32'(lo) - 32'($urandom_range(1));
        if ($urandom_range(7) == 0) v = 32'sh80000000;
      end
    endcase
    if (v != 32'sh80000000 && $urandom_range(1)) v = -v;
    return v;
  endfunction

  initial begin : stimulus
    int total_errors;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumDirected; i++) send_value(directed_values[i]);

    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      // last mix: output held off long enough for the input side to back up
      if (p == NumPhases - 1) hold_req = 1'b1;
      repeat (RandomPerPhase) send_value(random_int32());
    end
    in_valid = 1'b0;

    while (chars_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    total_errors = error_count + chars_pending;
    if (chars_pending != 0) $display("%0d characters never arrived", chars_pending);
    $display("converted %0d numbers (%0d negative) into %0d characters,",
             numbers_seen, negatives, chars_seen);
    $display("under four idling mixes and one long output hold-off");
    if (total_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
